/* sv/gpsi_pkg.sv */
// shared types, codes and helpers for the gamepad poll serial interface
package gpsi_pkg;

   // frame phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SETUP = 2'd1;
   localparam logic [1:0] PH_XFER  = 2'd2;
   localparam logic [1:0] PH_GAP   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_VIBRATE_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SETUP_TICKS    = 2'd1;
   localparam logic [1:0] CSR_GAP_TICKS      = 2'd2;

   // bytes sent on the command line, and the fill for a missing reply byte
   localparam logic [7:0] CMD_START     = 8'h01;
   localparam logic [7:0] CMD_POLL      = 8'h42;
   localparam logic [7:0] CMD_VIBRATE   = 8'h41;
   localparam logic [7:0] CMD_IDLE      = 8'h00;
   localparam logic [7:0] REPLY_MISSING = 8'hFF;

   localparam int unsigned NUM_REPLY = 6;
   localparam logic [3:0] BYTES_MIN    = 4'd2;
   localparam logic [3:0] BYTES_ANALOG = 4'd9;
   localparam logic [3:0] FIRST_REPLY  = 4'd3;
   localparam logic [3:0] LAST_REPLY   = 4'd8;

   localparam logic [7:0] STICK_BIAS = 8'd128;
   localparam logic [7:0] STICK_FLIP = 8'd127;

   typedef struct packed {
      logic poll_request;
      logic dat_in;
   } req_payload_type;

   typedef struct packed {
      logic              sel_out;
      logic              clk_out;
      logic              cmd_out;
      logic              frame_done;
      logic [15:0]       buttons;
      logic signed [7:0] right_stick_x;
      logic signed [7:0] right_stick_y;
      logic signed [7:0] left_stick_x;
      logic signed [7:0] left_stick_y;
      logic              analog_active;
   } rsp_payload_type;

   typedef struct packed {
      logic       vibrate_enable;
      logic [7:0] setup_ticks;
      logic [5:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [15:0] buttons;
      logic [7:0]  rx;
      logic [7:0]  ry;
      logic [7:0]  lx;
      logic [7:0]  ly;
      logic        analog;
   } decoded_type;

   typedef struct packed {
      logic [1:0]                     phase;
      logic [7:0]                     tick_count;
      logic [3:0]                     byte_index;
      logic [3:0]                     bytes_total;
      logic [7:0]                     shift_out;
      logic [7:0]                     shift_in;
      logic [NUM_REPLY-1:0][7:0]      reply_bytes;
      decoded_type                    decoded;
   } state_type;

   // command byte for a given position in the frame
   function automatic logic [7:0] byte_to_send(input logic [3:0] idx, input logic vib);
      logic [7:0] b;
      if (idx == 4'd0) begin
         b = CMD_START;
      end else if (idx == 4'd1) begin
         b = CMD_POLL;
      end else if (vib) begin
         b = CMD_VIBRATE;
      end else begin
         b = CMD_IDLE;
      end
      return b;
   endfunction

endpackage

/* sv/gpsi_step.sv */
// one tick of the pad link: next frame state and line levels
module gpsi_step (
   input  gpsi_pkg::state_type       state_cur,
   input  gpsi_pkg::cfg_type         cfg,
   input  gpsi_pkg::req_payload_type req,
   output gpsi_pkg::state_type       state_nxt,
   output gpsi_pkg::rsp_payload_type rsp
);

   logic       sel;
   logic       clk_lvl;
   logic       cmd;
   logic       done;
   logic [3:0] t;
   logic [2:0] bit_sel;
   logic [7:0] tick_inc;
   logic [7:0] sin_new;
   logic [3:0] idx_inc;
   logic [3:0] idx_rep;
   logic       finish;
   logic [3:0] total_sel;
   gpsi_pkg::state_type st;

   assign t        = state_cur.tick_count[3:0];
   assign bit_sel  = t[3:1];
   assign tick_inc = state_cur.tick_count + 8'd1;
   assign sin_new  = state_cur.shift_in | (8'(req.dat_in) << bit_sel);
   assign idx_inc  = state_cur.byte_index + 4'd1;
   assign idx_rep  = state_cur.byte_index - gpsi_pkg::FIRST_REPLY;

   // phase sequencing
   always_comb begin
      st        = state_cur;
      sel       = 1'b0;
      clk_lvl   = 1'b1;
      cmd       = 1'b1;
      finish    = 1'b0;
      total_sel = state_cur.bytes_total;
      case (state_cur.phase)
         gpsi_pkg::PH_IDLE: begin
            if (req.poll_request) begin
               st.phase       = gpsi_pkg::PH_SETUP;
               st.tick_count  = 8'd0;
               st.byte_index  = 4'd0;
               st.bytes_total = gpsi_pkg::BYTES_MIN;
               for (int i = 0; i < gpsi_pkg::NUM_REPLY; i++) begin
                  st.reply_bytes[i] = gpsi_pkg::REPLY_MISSING;
               end
            end else begin
               sel = 1'b1;
            end
         end
         gpsi_pkg::PH_SETUP: begin
            st.tick_count = tick_inc;
            if (tick_inc >= cfg.setup_ticks) begin
               st.phase      = gpsi_pkg::PH_XFER;
               st.tick_count = 8'd0;
               st.byte_index = 4'd0;
               st.shift_out  = gpsi_pkg::byte_to_send(4'd0, cfg.vibrate_enable);
               st.shift_in   = 8'd0;
            end
         end
         gpsi_pkg::PH_XFER: begin
            cmd = state_cur.shift_out[bit_sel];
            if (!t[0]) begin
               clk_lvl       = 1'b0;
               st.tick_count = 8'(t + 4'd1);
            end else begin
               st.shift_in = sin_new;
               if (t == 4'd15) begin
                  if (state_cur.byte_index == 4'd1) begin
                     st.bytes_total = 4'd3 + {1'b0, sin_new[1:0], 1'b0};
                  end else if (state_cur.byte_index >= gpsi_pkg::FIRST_REPLY &&
                               state_cur.byte_index <= gpsi_pkg::LAST_REPLY) begin
                     st.reply_bytes[idx_rep[2:0]] = sin_new;
                  end
                  st.tick_count = 8'd0;
                  if (cfg.gap_ticks == 6'd0) begin
                     finish = 1'b1;
                  end else begin
                     st.phase = gpsi_pkg::PH_GAP;
                  end
               end else begin
                  st.tick_count = 8'(t + 4'd1);
               end
            end
         end
         default: begin
            st.tick_count = tick_inc;
            if (tick_inc >= {2'b00, cfg.gap_ticks}) begin
               finish = 1'b1;
            end
         end
      endcase
      total_sel = st.bytes_total;
   end

   // advance to the next byte or close the frame
   always_comb begin
      state_nxt = st;
      done      = 1'b0;
      if (finish) begin
         state_nxt.byte_index = idx_inc;
         state_nxt.tick_count = 8'd0;
         if (idx_inc >= total_sel) begin
            done                    = 1'b1;
            state_nxt.phase         = gpsi_pkg::PH_IDLE;
            state_nxt.decoded.buttons =
               ~{st.reply_bytes[0], st.reply_bytes[1]};
            if (total_sel >= gpsi_pkg::BYTES_ANALOG) begin
               state_nxt.decoded.analog = 1'b1;
               state_nxt.decoded.rx = st.reply_bytes[2] - gpsi_pkg::STICK_BIAS;
               state_nxt.decoded.ry = gpsi_pkg::STICK_FLIP - st.reply_bytes[3];
               state_nxt.decoded.lx = st.reply_bytes[4] - gpsi_pkg::STICK_BIAS;
               state_nxt.decoded.ly = gpsi_pkg::STICK_FLIP - st.reply_bytes[5];
            end else begin
               state_nxt.decoded.analog = 1'b0;
               state_nxt.decoded.rx     = 8'd0;
               state_nxt.decoded.ry     = 8'd0;
               state_nxt.decoded.lx     = 8'd0;
               state_nxt.decoded.ly     = 8'd0;
            end
         end else begin
            state_nxt.phase     = gpsi_pkg::PH_XFER;
            state_nxt.shift_out = gpsi_pkg::byte_to_send(idx_inc, cfg.vibrate_enable);
            state_nxt.shift_in  = 8'd0;
         end
      end
   end

   // result word
   always_comb begin
      rsp.sel_out       = sel;
      rsp.clk_out       = clk_lvl;
      rsp.cmd_out       = cmd;
      rsp.frame_done    = done;
      rsp.buttons       = state_nxt.decoded.buttons;
      rsp.right_stick_x = state_nxt.decoded.rx;
      rsp.right_stick_y = state_nxt.decoded.ry;
      rsp.left_stick_x  = state_nxt.decoded.lx;
      rsp.left_stick_y  = state_nxt.decoded.ly;
      rsp.analog_active = state_nxt.decoded.analog;
   end

endmodule

/* sv/gamepad_poll_serial_interface.sv */
// gamepad poll serial interface top level: input register, tick step, result register
// an accepted word moves from the input register on to the result register
// throughput: one word per cycle unless rsp_ready holds the result register back;
// in a transfer a word is half a pad clock period; frame state is the only data loop
// reset (synchronous, active high): idle, config 0/9/11 -> vibrate off, setup 9,
// gap 11; reply bytes 0xFF, decoded results zero, both registers empty
module gamepad_poll_serial_interface (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gpsi_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gpsi_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_data
);

   logic                      in_valid_ff;
   gpsi_pkg::req_payload_type in_data_ff;
   logic                      out_valid_ff;
   gpsi_pkg::rsp_payload_type out_data_ff;
   gpsi_pkg::state_type       state_ff;
   gpsi_pkg::state_type       state_in;
   gpsi_pkg::rsp_payload_type rsp_in;
   gpsi_pkg::cfg_type         cfg_ff;
   logic                      advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vibrate_enable <= 1'b0;
         cfg_ff.setup_ticks    <= 8'd9;
         cfg_ff.gap_ticks      <= 6'd11;
      end else if (csr_valid) begin
         unique case (csr_index)
            gpsi_pkg::CSR_VIBRATE_ENABLE: cfg_ff.vibrate_enable <= csr_data[0];
            gpsi_pkg::CSR_SETUP_TICKS:    cfg_ff.setup_ticks    <= csr_data;
            gpsi_pkg::CSR_GAP_TICKS:      cfg_ff.gap_ticks      <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // tick logic
   gpsi_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .req       (in_data_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= gpsi_pkg::PH_IDLE;
         state_ff.tick_count  <= 8'd0;
         state_ff.byte_index  <= 4'd0;
         state_ff.bytes_total <= gpsi_pkg::BYTES_MIN;
         state_ff.shift_out   <= 8'd0;
         state_ff.shift_in    <= 8'd0;
         for (int i = 0; i < gpsi_pkg::NUM_REPLY; i++) begin
            state_ff.reply_bytes[i] <= gpsi_pkg::REPLY_MISSING;
         end
         state_ff.decoded     <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // select is low on the completion word
   a_done_sel_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> !rsp_data.sel_out)
      else $error("frame_done with select high");

   // pad clock only pulses low inside a frame
   a_clk_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.clk_out |-> !rsp_data.sel_out)
      else $error("pad clock low with select high");

   // sticks read zero outside analog mode
   a_digital_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.analog_active |->
         rsp_data.right_stick_x == 8'sd0 && rsp_data.right_stick_y == 8'sd0 &&
         rsp_data.left_stick_x == 8'sd0 && rsp_data.left_stick_y == 8'sd0)
      else $error("stick value outside analog mode");

   // a result is produced for every word leaving the input register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("word lost between registers");
`endif

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the gamepad poll serial interface against a tick predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int IDLE_PERCENT = 28;

   // how the reply bytes of a generated frame are filled
   localparam int FILL_SHAPED = 0;
   localparam int FILL_ONES   = 1;
   localparam int FILL_ZEROS  = 2;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   gpsi_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   gpsi_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index = '0;
   logic [7:0]                csr_data = '0;

   gpsi_pkg::req_payload_type tick_words[$];
   gpsi_pkg::rsp_payload_type expected_ticks[$];
   int                        fail_count = 0;
   int                        cycle_count = 0;
   int                        stall_cycles = 0;
   logic                      quiet_stretch;

   // predictor copy of the link state and its registers
   gpsi_pkg::cfg_type     pad_cfg;
   logic [1:0]            pad_phase;
   logic [7:0]            pad_ticks;
   logic [3:0]            pad_index;
   logic [3:0]            pad_total;
   logic [7:0]            pad_shout;
   logic [7:0]            pad_shin;
   logic [7:0]            pad_reply [gpsi_pkg::NUM_REPLY];
   gpsi_pkg::decoded_type pad_dec;

   gamepad_poll_serial_interface uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // no idling on either side during this window
   assign quiet_stretch = (cycle_count % 3000) < 700;

   function automatic void pad_reset();
      pad_cfg.vibrate_enable = 1'b0;
      pad_cfg.setup_ticks = 8'd9;
      pad_cfg.gap_ticks = 6'd11;
      pad_phase = gpsi_pkg::PH_IDLE;
      pad_ticks = '0;
      pad_index = '0;
      pad_total = gpsi_pkg::BYTES_MIN;
      pad_shout = '0;
      pad_shin = '0;
      foreach (pad_reply[i]) pad_reply[i] = gpsi_pkg::REPLY_MISSING;
      pad_dec = '0;
   endfunction

   // move to the next byte, or close the frame and decode; 1 when the frame is done
   function automatic logic pad_next_byte();
      pad_index = pad_index + 4'd1;
      if (pad_index >= pad_total) begin
         pad_dec.buttons = ~{pad_reply[0], pad_reply[1]};
         if (pad_total >= gpsi_pkg::BYTES_ANALOG) begin
            pad_dec.analog = 1'b1;
            pad_dec.rx = pad_reply[2] - gpsi_pkg::STICK_BIAS;
            pad_dec.ry = gpsi_pkg::STICK_FLIP - pad_reply[3];
            pad_dec.lx = pad_reply[4] - gpsi_pkg::STICK_BIAS;
            pad_dec.ly = gpsi_pkg::STICK_FLIP - pad_reply[5];
         end else begin
            pad_dec.analog = 1'b0;
            pad_dec.rx = '0;
            pad_dec.ry = '0;
            pad_dec.lx = '0;
            pad_dec.ly = '0;
         end
         pad_phase = gpsi_pkg::PH_IDLE;
         pad_ticks = '0;
         return 1'b1;
      end
      if (pad_index == 4'd1) begin
         pad_shout = gpsi_pkg::CMD_POLL;
      end else begin
         pad_shout = pad_cfg.vibrate_enable ? gpsi_pkg::CMD_VIBRATE : gpsi_pkg::CMD_IDLE;
      end
      pad_shin = '0;
      pad_ticks = '0;
      pad_phase = gpsi_pkg::PH_XFER;
      return 1'b0;
   endfunction

   // line levels and decoded fields for one tick of the link
   function automatic gpsi_pkg::rsp_payload_type pad_link_tick(
      input gpsi_pkg::req_payload_type w);
      gpsi_pkg::rsp_payload_type r;
      logic [3:0]                t;
      logic [2:0]                bitpos;
      logic [3:0]                rep_pos;
      r = '0;
      r.clk_out = 1'b1;
      r.cmd_out = 1'b1;
      case (pad_phase)
         gpsi_pkg::PH_IDLE: begin
            if (w.poll_request) begin
               pad_phase = gpsi_pkg::PH_SETUP;
               pad_ticks = '0;
               pad_index = '0;
               pad_total = gpsi_pkg::BYTES_MIN;
               foreach (pad_reply[i]) pad_reply[i] = gpsi_pkg::REPLY_MISSING;
            end else begin
               r.sel_out = 1'b1;
            end
         end
         gpsi_pkg::PH_SETUP: begin
            pad_ticks = pad_ticks + 8'd1;
            if (pad_ticks >= pad_cfg.setup_ticks) begin
               pad_phase = gpsi_pkg::PH_XFER;
               pad_ticks = '0;
               pad_index = '0;
               pad_shout = gpsi_pkg::CMD_START;
               pad_shin = '0;
            end
         end
         gpsi_pkg::PH_XFER: begin
            t = pad_ticks[3:0];
            bitpos = t[3:1];
            r.cmd_out = pad_shout[bitpos];
            if (!t[0]) begin
               // clock low, command bit on the line
               r.clk_out = 1'b0;
               pad_ticks = {4'd0, t} + 8'd1;
            end else begin
               // clock high, data bit sampled
               pad_shin[bitpos] = pad_shin[bitpos] | w.dat_in;
               if (t == 4'd15) begin
                  if (pad_index == 4'd1) begin
                     pad_total = 4'd3 + {1'b0, pad_shin[1:0], 1'b0};
                  end else if (pad_index >= gpsi_pkg::FIRST_REPLY &&
                               pad_index <= gpsi_pkg::LAST_REPLY) begin
                     rep_pos = pad_index - gpsi_pkg::FIRST_REPLY;
                     pad_reply[rep_pos[2:0]] = pad_shin;
                  end
                  pad_ticks = '0;
                  if (pad_cfg.gap_ticks == 6'd0) begin
                     r.frame_done = pad_next_byte();
                  end else begin
                     pad_phase = gpsi_pkg::PH_GAP;
                  end
               end else begin
                  pad_ticks = {4'd0, t} + 8'd1;
               end
            end
         end
         default: begin
            pad_ticks = pad_ticks + 8'd1;
            if (pad_ticks >= {2'b00, pad_cfg.gap_ticks}) r.frame_done = pad_next_byte();
         end
      endcase
      r.buttons = pad_dec.buttons;
      r.right_stick_x = pad_dec.rx;
      r.right_stick_y = pad_dec.ry;
      r.left_stick_x = pad_dec.lx;
      r.left_stick_y = pad_dec.ly;
      r.analog_active = pad_dec.analog;
      return r;
   endfunction

   task automatic push_word(input logic poll, input logic dat);
      gpsi_pkg::req_payload_type w;
      w.poll_request = poll;
      w.dat_in = dat;
      tick_words.push_back(w);
   endtask

   function automatic logic [7:0] shaped_byte();
      logic [7:0] b;
      case ($urandom_range(0, 4))
         0: b = 8'h00;
         1: b = 8'hFF;
         2: b = 8'h80;
         3: b = 8'h7F;
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   // ticks a full frame can take with the current registers
   function automatic int longest_frame();
      int nsetup;
      nsetup = (pad_cfg.setup_ticks == 8'd0) ? 1 : int'(pad_cfg.setup_ticks);
      return 1 + nsetup + 9 * (16 + int'(pad_cfg.gap_ticks));
   endfunction

   // one well-formed frame: request, setup, bytes with reply bits on the sampling ticks
   task automatic queue_frame(input int fill, input int len_code);
      logic [7:0] frame_bytes [9];
      int         nbytes;
      int         nsetup;
      foreach (frame_bytes[k]) begin
         case (fill)
            FILL_ONES: frame_bytes[k] = 8'hFF;
            FILL_ZEROS: frame_bytes[k] = 8'h00;
            default: frame_bytes[k] = shaped_byte();
         endcase
      end
      if (len_code >= 0) frame_bytes[1][1:0] = len_code[1:0];
      nbytes = 3 + 2 * int'(frame_bytes[1][1:0]);
      nsetup = (pad_cfg.setup_ticks == 8'd0) ? 1 : int'(pad_cfg.setup_ticks);
      push_word(1'b1, 1'($urandom));
      // a poll while busy is ignored, so sprinkle a few
      repeat (nsetup) push_word($urandom_range(0, 9) == 0, 1'($urandom));
      for (int k = 0; k < nbytes; k++) begin
         for (int t = 0; t < 16; t++) begin
            push_word($urandom_range(0, 9) == 0,
                      (t % 2 == 1) ? frame_bytes[k][t / 2] : 1'($urandom));
         end
         repeat (pad_cfg.gap_ticks) push_word($urandom_range(0, 9) == 0, 1'($urandom));
      end
      repeat ($urandom_range(0, 3)) push_word(1'b0, 1'($urandom));
   endtask

   // random junk, then enough quiet ticks for any frame it started to finish
   task automatic queue_noise();
      repeat ($urandom_range(4, 12)) push_word($urandom_range(0, 3) == 0, 1'($urandom));
      repeat (longest_frame()) push_word(1'b0, 1'($urandom));
   endtask

   task automatic queue_random(input int budget);
      int mark;
      mark = tick_words.size();
      while (tick_words.size() - mark < budget) begin
         if ($urandom_range(0, 7) == 0) queue_noise();
         else queue_frame(FILL_SHAPED, -1);
      end
   endtask

   // wait until every word is sent and every result checked
   task automatic wait_drain();
      do @(negedge clock);
      while (tick_words.size() != 0 || req_valid || expected_ticks.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         gpsi_pkg::CSR_VIBRATE_ENABLE: pad_cfg.vibrate_enable = value[0];
         gpsi_pkg::CSR_SETUP_TICKS: pad_cfg.setup_ticks = value;
         gpsi_pkg::CSR_GAP_TICKS: pad_cfg.gap_ticks = value[5:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic vib, input logic [7:0] setup, input logic [5:0] gap);
      write_csr(gpsi_pkg::CSR_VIBRATE_ENABLE, {7'd0, vib});
      write_csr(gpsi_pkg::CSR_SETUP_TICKS, setup);
      write_csr(gpsi_pkg::CSR_GAP_TICKS, {2'b00, gap});
   endtask

   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", fname, want, got);
         fail_count++;
      end
   endtask

   // stimulus sequence
   initial begin
      pad_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle ticks, then a full analog frame of all ones
      push_word(1'b0, 1'b0);
      push_word(1'b0, 1'b1);
      push_word(1'b0, 1'b0);
      queue_frame(FILL_ONES, -1);
      wait_drain();

      // zero setup and zero gap, shortest frame of all zeros first
      set_config(1'b1, 8'd0, 6'd0);
      queue_frame(FILL_ZEROS, -1);
      queue_random(50);
      wait_drain();

      set_config(1'b0, 8'd1, 6'd1);
      queue_random(50);
      wait_drain();

      // longest setup and gap, one short frame
      set_config(1'b1, 8'd255, 6'd63);
      queue_frame(FILL_SHAPED, 0);
      wait_drain();

      set_config(1'b0, 8'd2, 6'd0);
      queue_random(50);
      wait_drain();

      set_config(1'b1, 8'd4, 6'd3);
      queue_random(50);
      wait_drain();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // request driver: predicts each accepted word, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_ticks.push_back(pad_link_tick(req_data));
         if (!req_valid || req_ready) begin
            if (tick_words.size() != 0 &&
                (quiet_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_data <= tick_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares each accepted word with the oldest expectation
   always @(posedge clock) begin
      gpsi_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ticks.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("sel_out", 16'(want.sel_out), 16'(rsp_data.sel_out));
               check_field("clk_out", 16'(want.clk_out), 16'(rsp_data.clk_out));
               check_field("cmd_out", 16'(want.cmd_out), 16'(rsp_data.cmd_out));
               check_field("frame_done", 16'(want.frame_done), 16'(rsp_data.frame_done));
               check_field("buttons", want.buttons, rsp_data.buttons);
               check_field("right_stick_x", 16'(want.right_stick_x),
                           16'(rsp_data.right_stick_x));
               check_field("right_stick_y", 16'(want.right_stick_y),
                           16'(rsp_data.right_stick_y));
               check_field("left_stick_x", 16'(want.left_stick_x),
                           16'(rsp_data.left_stick_x));
               check_field("left_stick_y", 16'(want.left_stick_y),
                           16'(rsp_data.left_stick_y));
               check_field("analog_active", 16'(want.analog_active),
                           16'(rsp_data.analog_active));
            end
         end
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
